// File: hw/rtl/pwl_pkg.sv
package pwl_pkg;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  localparam int unsigned CNT_W = 7;
  localparam int unsigned RES_W = 32;

  typedef struct packed {
    logic below;
    logic above;
  } range_flags_t;

endpackage

// File: hw/rtl/pwl_front.sv
module pwl_front #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned IDX_W      = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_start,
  input  logic                          in_kind,
  input  logic [5:0]                    in_point_index,
  input  logic signed [VALUE_BITS-1:0]  in_point_x,
  input  logic signed [VALUE_BITS-1:0]  in_point_y,
  input  logic signed [VALUE_BITS-1:0]  in_query_x,
  input  logic [pwl_pkg::CNT_W-1:0]     point_count,
  output logic                          front_busy,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic signed [VALUE_BITS-1:0]  q_x,
  output logic signed [VALUE_BITS-1:0]  q_x0,
  output logic signed [VALUE_BITS-1:0]  q_x1,
  output logic signed [VALUE_BITS-1:0]  q_y0,
  output logic signed [VALUE_BITS-1:0]  q_y1,
  output pwl_pkg::range_flags_t         q_flags
);
  import pwl_pkg::*;

  localparam int unsigned N_W = IDX_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_LAST, S_CHK, S_ADDR, S_CMP, S_RD0, S_RD1, S_RD2, S_OUT
  } state_t;

  logic signed [VALUE_BITS-1:0] xmem [MAX_POINTS];
  logic signed [VALUE_BITS-1:0] ymem [MAX_POINTS];

  state_t                       state_r;
  logic [N_W-1:0]               n_r, lo_r, hi_r;
  logic signed [VALUE_BITS-1:0] qx_r, xrd_r, yrd_r, x0_r, y0_r, x1_r, y1_r;
  logic [IDX_W-1:0]             raddr;
  logic                         below_r, above_r;
  logic [N_W-1:0]               n_clamp, mid;
  logic                         wr_ok;

  always_comb begin
    if (point_count < 7'd2) begin
      n_clamp = N_W'(2);
    end else if (32'(point_count) > MAX_POINTS) begin
      n_clamp = N_W'(MAX_POINTS);
    end else begin
      n_clamp = N_W'(point_count);
    end
  end

  assign mid   = N_W'(((N_W+1)'(lo_r) + (N_W+1)'(hi_r)) >> 1);
  assign wr_ok = (32'(in_point_index) < MAX_POINTS);

  always_comb begin
    case (state_r)
      S_FIRST: raddr = IDX_W'(0);
      S_LAST:  raddr = IDX_W'(n_r - 1'b1);
      S_ADDR:  raddr = IDX_W'(mid);
      S_RD0:   raddr = IDX_W'(lo_r - 1'b1);
      S_RD1:   raddr = IDX_W'(lo_r);
      default: raddr = IDX_W'(0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_start && !front_busy && in_kind == KIND_WRITE && wr_ok) begin
      xmem[IDX_W'(in_point_index)] <= in_point_x;
      ymem[IDX_W'(in_point_index)] <= in_point_y;
    end
    xrd_r <= xmem[raddr];
    yrd_r <= ymem[raddr];
  end

  // The table read is registered: the data for each read address is used in the next state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      below_r <= 1'b0;
      above_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_start && in_kind == KIND_QUERY) begin
            qx_r    <= in_query_x;
            n_r     <= n_clamp;
            below_r <= 1'b0;
            above_r <= 1'b0;
            state_r <= S_FIRST;
          end
        end
        S_FIRST: state_r <= S_LAST;
        S_LAST: begin
          if (qx_r < xrd_r) begin
            below_r <= 1'b1;
          end
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (below_r) begin
            lo_r    <= N_W'(1);
            hi_r    <= N_W'(1);
            state_r <= S_RD0;
          end else if (qx_r > xrd_r) begin
            above_r <= 1'b1;
            lo_r    <= n_r - 1'b1;
            hi_r    <= n_r - 1'b1;
            state_r <= S_RD0;
          end else begin
            lo_r    <= N_W'(1);
            hi_r    <= n_r - 1'b1;
            state_r <= (n_r > N_W'(2)) ? S_ADDR : S_RD0;
          end
        end
        S_ADDR: state_r <= S_CMP;
        S_CMP: begin
          if (qx_r <= xrd_r) begin
            hi_r    <= mid;
            state_r <= (lo_r < mid) ? S_ADDR : S_RD0;
          end else begin
            lo_r    <= mid + 1'b1;
            state_r <= ((mid + 1'b1) < hi_r) ? S_ADDR : S_RD0;
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          x0_r    <= xrd_r;
          y0_r    <= yrd_r;
          state_r <= S_RD2;
        end
        S_RD2: begin
          x1_r    <= xrd_r;
          y1_r    <= yrd_r;
          state_r <= S_OUT;
        end
        S_OUT: if (q_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign front_busy = (state_r != S_IDLE);
  assign q_valid    = (state_r == S_OUT);
  assign q_x        = qx_r;
  assign q_x0       = x0_r;
  assign q_x1       = x1_r;
  assign q_y0       = y0_r;
  assign q_y1       = y1_r;
  assign q_flags    = '{below: below_r, above: above_r};

endmodule

// File: hw/rtl/pwl_back.sv
module pwl_back #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic signed [VALUE_BITS-1:0]  q_x,
  input  logic signed [VALUE_BITS-1:0]  q_x0,
  input  logic signed [VALUE_BITS-1:0]  q_x1,
  input  logic signed [VALUE_BITS-1:0]  q_y0,
  input  logic signed [VALUE_BITS-1:0]  q_y1,
  input  pwl_pkg::range_flags_t         q_flags,
  output logic                          out_strobe,
  output logic signed [pwl_pkg::RES_W-1:0] out_result_y,
  output logic                          out_below_range,
  output logic                          out_above_range,
  output logic                          out_zero_span
);
  import pwl_pkg::*;

  localparam int unsigned D_W  = VALUE_BITS + 1;
  localparam int unsigned P_W  = 2 * D_W;
  localparam int unsigned Q_W  = P_W;
  localparam int unsigned C_W  = $clog2(P_W + 1);
  localparam int unsigned S_W  = P_W + 2;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t                   state_r;
  logic [D_W-1:0]           ma_r, mb_r, md_r;
  logic                     neg_r, zero_r;
  logic signed [VALUE_BITS-1:0] y0_r;
  range_flags_t             flags_r;
  logic [P_W-1:0]           prod_r;
  logic [D_W:0]             rem_r;
  logic [Q_W-1:0]           quo_r;
  logic [C_W-1:0]           cnt_r;
  logic signed [D_W-1:0]    dx, dy, dd;
  logic [D_W:0]             rem_sh;
  logic signed [S_W-1:0]    sum;

  assign dx = D_W'(q_x1) - D_W'(q_x0);
  assign dy = D_W'(q_y1) - D_W'(q_y0);
  assign dd = D_W'(q_x)  - D_W'(q_x0);
  assign rem_sh = {rem_r[D_W-1:0], prod_r[P_W-1]};

  always_comb begin
    if (zero_r) begin
      sum = S_W'(y0_r);
    end else if (neg_r) begin
      sum = S_W'(y0_r) - $signed({2'b00, quo_r});
    end else begin
      sum = S_W'(y0_r) + $signed({2'b00, quo_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            ma_r    <= dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
            mb_r    <= dd[D_W-1] ? D_W'(-dd) : D_W'(dd);
            md_r    <= dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
            neg_r   <= (dy[D_W-1] ^ dd[D_W-1] ^ dx[D_W-1]) && dy != '0 && dd != '0;
            zero_r  <= (dx == '0);
            y0_r    <= q_y0;
            flags_r <= q_flags;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= P_W'(ma_r) * P_W'(mb_r);
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= C_W'(P_W);
          state_r <= zero_r ? S_FIN : S_DIV;
        end
        S_DIV: begin
          prod_r <= prod_r << 1;
          if (rem_sh >= (D_W+1)'(md_r)) begin
            rem_r <= rem_sh - (D_W+1)'(md_r);
            quo_r <= {quo_r[Q_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[Q_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == C_W'(1)) state_r <= S_FIN;
        end
        S_FIN: begin
          out_strobe      <= 1'b1;
          out_below_range <= flags_r.below;
          out_above_range <= flags_r.above;
          out_zero_span   <= zero_r;
          if (sum > S_W'(32'sh7FFF_FFFF)) begin
            out_result_y <= 32'sh7FFF_FFFF;
          end else if (sum < -S_W'(33'sh0_8000_0000)) begin
            out_result_y <= 32'sh8000_0000;
          end else begin
            out_result_y <= RES_W'(sum);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign q_ready = (state_r == S_IDLE);

endmodule

// File: hw/rtl/piecewise_linear_table_interp_core.sv
// The front end finds a query's segment by binary search in at most ceil(log2(point_count - 1))
// steps, point_count clamped to 2..MAX_POINTS, then reads both knots of that segment.
// The serial divider holds the back end for each query while the front end searches the
// next one; a write gives no result.
// Reset (rst_n, synchronous, active low) clears control and sets point_count to 2;
// the table holds whatever was written. The receiver cannot stall results.
module piecewise_linear_table_interp_core #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [5:0]                    in_point_index,
  input  logic signed [VALUE_BITS-1:0]  in_point_x,
  input  logic signed [VALUE_BITS-1:0]  in_point_y,
  input  logic signed [VALUE_BITS-1:0]  in_query_x,
  input  logic                          cfg_we,
  input  logic [pwl_pkg::CNT_W-1:0]     cfg_wdata,
  output logic                          out_strobe,
  output logic signed [pwl_pkg::RES_W-1:0] out_result_y,
  output logic                          out_below_range,
  output logic                          out_above_range,
  output logic                          out_zero_span
);
  import pwl_pkg::*;

  localparam int unsigned IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  logic [CNT_W-1:0]             point_count_r;
  logic                         front_busy, q_valid, q_ready;
  logic signed [VALUE_BITS-1:0] q_x, q_x0, q_x1, q_y0, q_y1;
  range_flags_t                 q_flags;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= CNT_W'(2);
    end else if (cfg_we) begin
      point_count_r <= cfg_wdata;
    end
  end

  assign busy = front_busy;

  pwl_front #(.MAX_POINTS(MAX_POINTS), .VALUE_BITS(VALUE_BITS), .IDX_W(IDX_W)) u_front (
    .clk, .rst_n, .in_start(start), .in_kind, .in_point_index, .in_point_x,
    .in_point_y, .in_query_x, .point_count(point_count_r), .front_busy,
    .q_valid, .q_ready, .q_x, .q_x0, .q_x1, .q_y0, .q_y1, .q_flags
  );

  pwl_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_x, .q_x0, .q_x1, .q_y0, .q_y1, .q_flags,
    .out_strobe, .out_result_y, .out_below_range, .out_above_range,
    .out_zero_span
  );

endmodule

// File: sim/pwl_checker.sv
`timescale 1ns / 100ps

module pwl_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_kind,
  input  logic [5:0]         in_point_index,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic signed [15:0] in_query_x,
  input  logic               cfg_we,
  input  logic [pwl_pkg::CNT_W-1:0] cfg_wdata,
  input  logic               out_strobe,
  input  logic signed [pwl_pkg::RES_W-1:0] out_result_y,
  input  logic               out_below_range,
  input  logic               out_above_range,
  input  logic               out_zero_span,
  output int                 fail_count,
  output int                 lookups_pending,
  output int                 results_seen
);
  import pwl_pkg::*;

  typedef struct packed {
    logic signed [RES_W-1:0] y;
    logic below;
    logic above;
    logic zspan;
  } lookup_t;

  logic signed [15:0] knot_x [64];
  logic signed [15:0] knot_y [64];
  logic [CNT_W-1:0]   knots_used;
  lookup_t            lookup_q [$];

  function automatic lookup_t interpolate(logic signed [15:0] qx);
    lookup_t r;
    int      n, lo, hi, mid, seg;
    longint  x0, x1, y0, y1, sum;
    n = (knots_used < 2) ? 2 : (knots_used > 64) ? 64 : int'(knots_used);
    r = '0;
    if (qx < knot_x[0]) begin
      r.below = 1'b1;
      seg = 0;
    end else if (qx > knot_x[n-1]) begin
      r.above = 1'b1;
      seg = n - 2;
    end else begin
      lo = 1;
      hi = n - 1;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (qx <= knot_x[mid]) hi = mid;
        else lo = mid + 1;
      end
      seg = lo - 1;
    end
    x0 = knot_x[seg];
    x1 = knot_x[seg+1];
    y0 = knot_y[seg];
    y1 = knot_y[seg+1];
    if (x1 == x0) begin
      r.zspan = 1'b1;
      sum = y0;
    end else begin
      sum = y0 + ((y1 - y0) * (longint'(qx) - x0)) / (x1 - x0);
    end
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    r.y = sum[31:0];
    return r;
  endfunction

  assign lookups_pending = lookup_q.size();

  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      knots_used <= 7'd2;
      lookup_q.delete();
      fail_count   <= 0;
      results_seen <= 0;
    end else begin
      if (out_strobe) begin
        results_seen <= results_seen + 1;
        if (lookup_q.size() == 0) begin
          $error("result beat with no lookup outstanding: y=%0d", out_result_y);
          fail_count <= fail_count + 1;
        end else begin
          want = lookup_q.pop_front();
          if (out_result_y !== want.y ||
              out_below_range !== want.below ||
              out_above_range !== want.above ||
              out_zero_span !== want.zspan)
            fail_count <= fail_count + 1;
          if (out_result_y !== want.y)
            $error("result_y: expected %0d, got %0d", want.y, out_result_y);
          if (out_below_range !== want.below)
            $error("below_range: expected %0b, got %0b", want.below, out_below_range);
          if (out_above_range !== want.above)
            $error("above_range: expected %0b, got %0b", want.above, out_above_range);
          if (out_zero_span !== want.zspan)
            $error("zero_span: expected %0b, got %0b", want.zspan, out_zero_span);
        end
      end
      if (start && !busy) begin
        if (in_kind == KIND_QUERY) begin
          lookup_q.push_back(interpolate(in_query_x));
        end else begin
          knot_x[in_point_index] <= in_point_x;
          knot_y[in_point_index] <= in_point_y;
        end
      end
      if (cfg_we) knots_used <= cfg_wdata;
    end
  end
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pwl_pkg::*;

  logic clk, rst_n, start, busy, in_kind, cfg_we;
  logic [5:0] in_point_index;
  logic signed [15:0] in_point_x, in_point_y, in_query_x;
  logic [CNT_W-1:0] cfg_wdata;
  logic out_strobe, out_below_range, out_above_range, out_zero_span;
  logic signed [RES_W-1:0] out_result_y;
  int fail_count, lookups_pending, results_seen;
  int idle_cycles, lookups_sent, knot_writes, phases;
  logic signed [15:0] tb_knot_x [64];
  logic no_gaps;
  logic [CNT_W-1:0] counts [10] = '{7'd64, 7'd5, 7'd17, 7'd0, 7'd3,
                                    7'd127, 7'd33, 7'd2, 7'd1, 7'd100};

  piecewise_linear_table_interp_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_point_index(in_point_index),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_query_x(in_query_x),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_result_y(out_result_y),
    .out_below_range(out_below_range), .out_above_range(out_above_range),
    .out_zero_span(out_zero_span)
  );

  pwl_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_beat(logic kind, logic [5:0] idx, logic signed [15:0] px,
                           logic signed [15:0] py, logic signed [15:0] qx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_point_index <= idx;
    in_point_x <= px;
    in_point_y <= py;
    in_query_x <= qx;
    #1;
    while (busy) @(negedge clk);
    @(posedge clk);
    if (kind == KIND_QUERY) begin
      lookups_sent++;
    end else begin
      knot_writes++;
      tb_knot_x[idx] = px;
    end
  endtask

  task automatic write_knot(int idx, int px, int py);
    send_beat(KIND_WRITE, idx[5:0], px[15:0], py[15:0], 16'($urandom));
  endtask

  task automatic query(int qx);
    send_beat(KIND_QUERY, 6'($urandom), 16'($urandom), 16'($urandom), qx[15:0]);
  endtask

  task automatic set_knot_count(logic [CNT_W-1:0] value);
    @(negedge clk) start <= 1'b0;
    while (lookups_pending != 0 || busy) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic fill_table(int n);
    int mode, span, base;
    mode = $urandom_range(0, 9);
    span = 65536 / n;
    for (int i = 0; i < n; i++) begin
      base = -32768 + i * span + $urandom_range(0, span - 1);
      if (mode == 0) base = $urandom_range(0, 65535) - 32768;
      else if (mode == 1 && i > 0 && $urandom_range(0, 3) == 0) base = tb_knot_x[i-1];
      write_knot(i, base, (mode < 5) ? $urandom_range(0, 65535) - 32768
                                      : $urandom_range(0, 511) - 256);
    end
  endtask

  task automatic run_phase(logic [CNT_W-1:0] value, int items);
    int n, k, qx;
    n = (value < 2) ? 2 : (value > 64) ? 64 : int'(value);
    set_knot_count(value);
    phases++;
    fill_table(n);
    for (int i = 0; i < items; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        write_knot($urandom_range(0, 63), $urandom_range(0, 65535) - 32768,
                   $urandom_range(0, 65535) - 32768);
      end else begin
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 3))
          0: qx = $urandom_range(0, 65535) - 32768;
          1: qx = tb_knot_x[k];
          default: qx = tb_knot_x[k] + $urandom_range(0, 600) - 300;
        endcase
        if (qx > 32767) qx = 32767;
        if (qx < -32768) qx = -32768;
        query(qx);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_kind = KIND_WRITE;
    in_point_index = '0;
    in_point_x = '0;
    in_point_y = '0;
    in_query_x = '0;
    no_gaps = 1'b0;
    idle_cycles = 0;
    lookups_sent = 0;
    knot_writes = 0;
    phases = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Steep unit-width segment at the bottom of the range drives both saturations.
    write_knot(0, -32768, -32768);
    write_knot(1, -32767, 32767);
    query(32767);
    query(-32768);
    query(-32767);
    write_knot(0, -32768, 32767);
    write_knot(1, -32767, -32768);
    query(32767);
    write_knot(0, 100, 25);
    write_knot(1, 100, -7);
    query(100);
    query(-32768);
    query(32767);
    write_knot(0, 0, 256);
    write_knot(1, 512, -256);
    query(-32768);
    query(0);
    query(512);
    query(255);
    query(-1);
    write_knot(63, 32767, 32767);

    foreach (counts[i]) run_phase(counts[i], 125);

    @(negedge clk) start <= 1'b0;
    while (lookups_pending != 0 || busy) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("Covered %0d lookups and %0d knot writes over %0d table sizes.",
             lookups_sent, knot_writes, phases);
    $display("Checked %0d result beats, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
